// ===== rtl/matrix3x3_inverse_defines.svh =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse_defines
// Assertion macros shared by the matrix inverse RTL.
// ----------------------------------------------------------------------------
`ifndef MATRIX3X3_INVERSE_DEFINES_SVH
`define MATRIX3X3_INVERSE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define MI3_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("matrix3x3_inverse: implication check failed");

// next-cycle implication
`define MI3_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("matrix3x3_inverse: next-cycle check failed");

`endif

// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg
// Constants and width helpers for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

	localparam int ENTRY_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int THR_W           = 31;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
	localparam int NLANE           = 9;

	function automatic int imax(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/matrix3x3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// Pipelined 3x3 inverse by cofactors and determinant, one bit of quotient
// per stage, saturated signed fixed-point results.
// ----------------------------------------------------------------------------
//  channel | signals                          | beat
//  --------+----------------------------------+-------------------------------
//  in      | in_valid/in_stall, in_r0c0..r2c2 | one matrix
//  out     | out_valid/out_stall, out_*, sing | one inverse or identity
//  cfg     | cfg_we, cfg_wdata                | det_threshold write
//
//  One matrix per cycle while the output is not stalled; the pipeline is built from
//  five product/determinant stages, ENTRY_WIDTH+1 restoring divider stages
//  (nine lanes, one quotient bit each) and the output register.
//  Reset clears the valid bits and sets det_threshold to 1.
//  A stalled output beat freezes the whole pipeline; nothing is lost.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "matrix3x3_inverse_defines.svh"

module matrix3x3_inverse #(
	parameter int ENTRY_WIDTH = mi3_pkg::ENTRY_WIDTH_DEF,
	parameter int FRAC_BITS   = mi3_pkg::FRAC_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [mi3_pkg::THR_W-1:0]      cfg_wdata,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r0c0,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r0c1,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r0c2,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r1c0,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r1c1,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r1c2,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r2c0,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r2c1,
	input  wire  signed [ENTRY_WIDTH-1:0]  in_r2c2,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic signed [ENTRY_WIDTH-1:0]  out_r0c0,
	output logic signed [ENTRY_WIDTH-1:0]  out_r0c1,
	output logic signed [ENTRY_WIDTH-1:0]  out_r0c2,
	output logic signed [ENTRY_WIDTH-1:0]  out_r1c0,
	output logic signed [ENTRY_WIDTH-1:0]  out_r1c1,
	output logic signed [ENTRY_WIDTH-1:0]  out_r1c2,
	output logic signed [ENTRY_WIDTH-1:0]  out_r2c0,
	output logic signed [ENTRY_WIDTH-1:0]  out_r2c1,
	output logic signed [ENTRY_WIDTH-1:0]  out_r2c2,
	output logic                           singular
);

	localparam int EW    = ENTRY_WIDTH;
	localparam int FB    = FRAC_BITS;
	localparam int NL    = mi3_pkg::NLANE;
	localparam int PW    = 2 * EW;
	localparam int CW    = 2 * EW + 1;
	localparam int XW    = 2 * EW + 1;
	localparam int DW    = 3 * EW + 3;
	localparam int NW    = CW + 2 * FB;
	localparam int QW    = EW + 1;
	localparam int NST   = EW + 1;
	localparam int CMPW  = mi3_pkg::imax(NW, DW + EW);
	localparam int TW    = mi3_pkg::imax(DW, mi3_pkg::THR_W + 2 * FB);
	localparam logic [EW-1:0] ONE_FX  = EW'(1) << FB;
	localparam logic [QW-1:0] LIM     = QW'(1) << (EW - 1);
	localparam logic [EW-1:0] MAX_POS = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] MAX_NEG = {1'b1, {(EW-1){1'b0}}};

	logic [mi3_pkg::THR_W-1:0] thr_q;
	logic                      adv;

	logic signed [EW-1:0] m [3][3];

	logic                 vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [PW-1:0] pa_s1 [3][3];
	logic signed [PW-1:0] pb_s1 [3][3];
	logic signed [EW-1:0] m0_s1 [3];
	logic signed [CW-1:0] cof_s2 [3][3];
	logic signed [EW-1:0] m0_s2 [3];
	logic signed [CW-1:0] cof_s3 [3][3];
	logic signed [XW-1:0] pl_s3 [3];
	logic signed [XW-1:0] ph_s3 [3];
	logic signed [CW-1:0] cof_s4 [3][3];
	logic signed [DW-1:0] det_s4;

	logic                 vld_s  [NST+1];
	logic [NW-1:0]        rem_s  [NST+1][NL];
	logic [QW-1:0]        quo_s  [NST+1][NL];
	logic [DW-1:0]        den_s  [NST+1];
	logic [NL-1:0]        neg_s  [NST+1];
	logic                 sing_s [NST+1];

	logic                 vld_o_q;
	logic [EW-1:0]        res_o_q [NL];
	logic                 sing_o_q;

	assign adv      = !vld_o_q || !out_stall;
	assign in_stall = !adv;

	assign m[0][0] = in_r0c0;
	assign m[0][1] = in_r0c1;
	assign m[0][2] = in_r0c2;
	assign m[1][0] = in_r1c0;
	assign m[1][1] = in_r1c1;
	assign m[1][2] = in_r1c2;
	assign m[2][0] = in_r2c0;
	assign m[2][1] = in_r2c1;
	assign m[2][2] = in_r2c2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= mi3_pkg::THR_RESET;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s[0]  <= 1'b0;
			vld_o_q   <= 1'b0;
		end else if (adv) begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s[0]  <= vld_s4;
			vld_o_q   <= vld_s[NST];
		end
	end

	// minor products and cofactors
	for (genvar gi = 0; gi < 3; gi++) begin : g_row
		localparam int I1 = (gi + 1) % 3;
		localparam int I2 = (gi + 2) % 3;
		for (genvar gj = 0; gj < 3; gj++) begin : g_col
			localparam int J1 = (gj + 1) % 3;
			localparam int J2 = (gj + 2) % 3;
			always_ff @(posedge clk) begin
				if (adv) begin
					pa_s1[gi][gj]  <= m[I1][J1] * m[I2][J2];
					pb_s1[gi][gj]  <= m[I1][J2] * m[I2][J1];
					cof_s2[gi][gj] <= CW'(pa_s1[gi][gj]) - CW'(pb_s1[gi][gj]);
					cof_s3[gi][gj] <= cof_s2[gi][gj];
					cof_s4[gi][gj] <= cof_s3[gi][gj];
				end
			end
		end
	end

	// determinant: each term split into low and high partial products
	for (genvar gj = 0; gj < 3; gj++) begin : g_det
		always_ff @(posedge clk) begin
			if (adv) begin
				m0_s1[gj] <= m[0][gj];
				m0_s2[gj] <= m0_s1[gj];
				pl_s3[gj] <= m0_s2[gj] * $signed({1'b0, cof_s2[0][gj][EW-1:0]});
				ph_s3[gj] <= m0_s2[gj] * $signed(cof_s2[0][gj][CW-1:EW]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s4 <= (DW'(ph_s3[0]) <<< EW) + DW'(pl_s3[0])
				+ (DW'(ph_s3[1]) <<< EW) + DW'(pl_s3[1])
				+ (DW'(ph_s3[2]) <<< EW) + DW'(pl_s3[2]);
		end
	end

	// magnitudes, signs and singular test
	always_ff @(posedge clk) begin
		logic [DW-1:0] adet;
		logic [CW-1:0] acof;
		logic          dneg;
		if (adv) begin
			dneg = det_s4[DW-1];
			adet = dneg ? DW'(-det_s4) : DW'(det_s4);
			den_s[0]  <= adet;
			sing_s[0] <= (det_s4 == '0)
				|| (TW'(adet) < (TW'(thr_q) << (2 * FB)));
			for (int l = 0; l < NL; l++) begin
				acof = cof_s4[l % 3][l / 3][CW-1] ? CW'(-cof_s4[l % 3][l / 3])
					: CW'(cof_s4[l % 3][l / 3]);
				rem_s[0][l] <= NW'(acof) << (2 * FB);
				quo_s[0][l] <= '0;
				neg_s[0][l] <= cof_s4[l % 3][l / 3][CW-1] ^ dneg;
			end
		end
	end

	// restoring divider, one quotient bit per stage, MSB first
	for (genvar gk = 0; gk < NST; gk++) begin : g_div
		localparam int B = EW - gk;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[gk+1] <= 1'b0;
			end else if (adv) begin
				vld_s[gk+1] <= vld_s[gk];
			end
		end
		always_ff @(posedge clk) begin
			logic [CMPW-1:0] dsh;
			logic [CMPW-1:0] rx;
			logic [QW-1:0]   qn;
			logic            ge;
			if (adv) begin
				dsh = CMPW'(den_s[gk]) << B;
				den_s[gk+1]  <= den_s[gk];
				neg_s[gk+1]  <= neg_s[gk];
				sing_s[gk+1] <= sing_s[gk];
				for (int l = 0; l < NL; l++) begin
					rx    = CMPW'(rem_s[gk][l]);
					ge    = rx >= dsh;
					qn    = quo_s[gk][l];
					qn[B] = ge;
					rem_s[gk+1][l] <= ge ? NW'(rx - dsh) : rem_s[gk][l];
					quo_s[gk+1][l] <= qn;
				end
			end
		end
	end

	// saturation and identity select
	always_ff @(posedge clk) begin
		logic [QW-1:0] q;
		if (adv) begin
			sing_o_q <= sing_s[NST];
			for (int l = 0; l < NL; l++) begin
				q = quo_s[NST][l];
				if (sing_s[NST]) begin
					res_o_q[l] <= (l % 4 == 0) ? ONE_FX : '0;
				end else if (neg_s[NST][l]) begin
					res_o_q[l] <= (q > LIM) ? MAX_NEG : EW'(-q);
				end else begin
					res_o_q[l] <= (q > LIM - QW'(1)) ? MAX_POS : EW'(q);
				end
			end
		end
	end

	assign out_valid = vld_o_q;
	assign singular  = sing_o_q;
	assign out_r0c0  = res_o_q[0];
	assign out_r0c1  = res_o_q[1];
	assign out_r0c2  = res_o_q[2];
	assign out_r1c0  = res_o_q[3];
	assign out_r1c1  = res_o_q[4];
	assign out_r1c2  = res_o_q[5];
	assign out_r2c0  = res_o_q[6];
	assign out_r2c1  = res_o_q[7];
	assign out_r2c2  = res_o_q[8];

	`MI3_ASSERT_IMP(a_sing_identity, out_valid && singular, out_r1c1 == ONE_FX && out_r0c1 == '0)
	`MI3_ASSERT_NXT(a_beat_enters, in_valid && !in_stall, vld_s1)
	`MI3_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_r1c2))

endmodule

`default_nettype wire

// ===== tb/matrix3x3_inverse_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse_tb
// Drives directed and random 3x3 matrices through the inverse pipeline under
// random source gaps and sink stalls, rebuilds each inverse not in the table
// with exact wide cofactor arithmetic and checks every output beat in order.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_tb;

	localparam logic [31:0] ONE     = 32'h0001_0000;
	localparam logic [31:0] EMAX    = 32'h7fff_ffff;
	localparam logic [31:0] EMIN    = 32'h8000_0000;
	localparam int          LIMIT   = 5000;
	localparam int          DRAIN   = 50;
	localparam int          NDIR    = 14;

	typedef struct {
		logic [31:0] v[9];
		logic        sing;
	} inv_t;

	typedef struct {
		logic [31:0] m[9];
		bit          chk;
		inv_t        res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [30:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] in_m[9] = '{default: '0};
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] out_m[9];
	logic        singular;

	logic [30:0] thr_model = 31'd1;
	inv_t        inv_q[$];
	bit          failed = 1'b0;
	int          tx_pct = 0;
	int          rx_pct = 0;
	bit          hold_go = 1'b0;
	bit          hold_seen = 1'b0;
	int          hold_cnt = 0;
	int          quiet = 0;

	matrix3x3_inverse u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_r0c0(in_m[0]), .in_r0c1(in_m[1]), .in_r0c2(in_m[2]),
		.in_r1c0(in_m[3]), .in_r1c1(in_m[4]), .in_r1c2(in_m[5]),
		.in_r2c0(in_m[6]), .in_r2c1(in_m[7]), .in_r2c2(in_m[8]),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_r0c0(out_m[0]), .out_r0c1(out_m[1]), .out_r0c2(out_m[2]),
		.out_r1c0(out_m[3]), .out_r1c1(out_m[4]), .out_r1c2(out_m[5]),
		.out_r2c0(out_m[6]), .out_r2c1(out_m[7]), .out_r2c2(out_m[8]),
		.singular(singular)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic inv_t invert(logic [31:0] a[9], logic [30:0] thr);
		logic signed [127:0] e[9];
		logic signed [127:0] c[9];
		logic signed [127:0] det;
		logic signed [127:0] num;
		logic [127:0]        ad;
		logic [127:0]        an;
		logic [127:0]        qu;
		logic [127:0]        tw;
		inv_t                r;
		int                  i1, i2, j1, j2;
		bit                  neg;
		for (int k = 0; k < 9; k++)
			e[k] = {{96{a[k][31]}}, a[k]};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				i1 = (i + 1) % 3; i2 = (i + 2) % 3;
				j1 = (j + 1) % 3; j2 = (j + 2) % 3;
				c[i*3+j] = e[i1*3+j1] * e[i2*3+j2] - e[i1*3+j2] * e[i2*3+j1];
			end
		end
		det = e[0] * c[0] + e[1] * c[1] + e[2] * c[2];
		ad = det[127] ? -det : det;
		tw = {97'b0, thr} << 32;
		if (det == 0 || ad < tw) begin
			for (int k = 0; k < 9; k++)
				r.v[k] = (k % 4 == 0) ? ONE : 32'h0;
			r.sing = 1'b1;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				num = c[j*3+i] <<< 32;
				neg = num[127] ^ det[127];
				an = num[127] ? -num : num;
				qu = an / ad;
				if (neg) begin
					if (qu > 128'h8000_0000)
						qu = 128'h8000_0000;
					qu = -qu;
				end else if (qu > 128'h7fff_ffff) begin
					qu = 128'h7fff_ffff;
				end
				r.v[i*3+j] = qu[31:0];
			end
		end
		r.sing = 1'b0;
		return r;
	endfunction

	// one matrix beat; expectation queued at acceptance
	task automatic send_matrix(logic [31:0] a[9], bit use_typed, inv_t typed);
		while ($urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		for (int k = 0; k < 9; k++)
			in_m[k] <= a[k];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		inv_q.push_back(use_typed ? typed : invert(a, thr_model));
	endtask

	task automatic write_threshold(logic [30:0] v);
		in_valid <= 1'b0;
		@(posedge clk);
		while (inv_q.size() != 0)
			@(posedge clk);
		repeat (45) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_model = v;
	endtask

	always @(posedge clk) begin
		if (hold_go && !hold_seen) begin
			hold_seen <= 1'b1;
			hold_cnt  <= 300;
			out_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_pct);
		end
	end

	always @(posedge clk) begin
		inv_t exp_inv;
		if (arst_n && out_valid && !out_stall) begin
			if (inv_q.size() == 0) begin
				$error("output beat with nothing expected");
				failed = 1'b1;
			end else begin
				exp_inv = inv_q.pop_front();
				for (int k = 0; k < 9; k++) begin
					if (out_m[k] !== exp_inv.v[k]) begin
						$error("out_r%0dc%0d: expected %h, got %h", k / 3, k % 3,
							exp_inv.v[k], out_m[k]);
						failed = 1'b1;
					end
				end
				if (singular !== exp_inv.sing) begin
					$error("singular: expected %b, got %b", exp_inv.sing, singular);
					failed = 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= LIMIT) begin
			$display("matrix3x3_inverse: mismatch");
			$finish;
		end
	end

	initial begin
		dir_row_t    dir[NDIR];
		inv_t        idn;
		inv_t        sng;
		inv_t        none;
		logic [31:0] a[9];
		logic [31:0] pick[5];
		int          kind;
		int          seg_thr[4];
		int          seg_mode[4];
		int          seg_n[4];

		idn.v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
		idn.sing = 1'b0;
		sng = idn;
		sng.sing = 1'b1;
		none = idn;
		pick = '{EMAX, EMIN, 32'h0, ONE, -ONE};

		dir[0]  = '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}, 1'b1, idn};
		dir[1]  = '{'{default: 32'h0}, 1'b1, sng};
		dir[2]  = '{'{default: EMAX}, 1'b1, sng};
		dir[3]  = '{'{default: EMIN}, 1'b1, sng};
		dir[4]  = '{'{1, 0, 0, 0, 1, 0, 0, 0, 1}, 1'b1, sng};
		dir[5]  = '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, 1}, 1'b1,
			'{'{ONE, 0, 0, 0, ONE, 0, 0, 0, EMAX}, 1'b0}};
		dir[6]  = '{'{ONE, 0, 0, 0, ONE, 0, 0, 0, -1}, 1'b1,
			'{'{ONE, 0, 0, 0, ONE, 0, 0, 0, EMIN}, 1'b0}};
		dir[7]  = '{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b1,
			'{'{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}, 1'b0}};
		dir[8]  = '{'{32'h2_0000, 0, 0, 0, 32'h2_0000, 0, 0, 0, 32'h2_0000}, 1'b1,
			'{'{32'h8000, 0, 0, 0, 32'h8000, 0, 0, 0, 32'h8000}, 1'b0}};
		dir[9]  = '{'{EMAX, 0, 0, 0, EMAX, 0, 0, 0, EMAX}, 1'b0, none};
		dir[10] = '{'{EMIN, 0, 0, 0, EMIN, 0, 0, 0, EMIN}, 1'b0, none};
		dir[11] = '{'{0, ONE, 0, 0, 0, ONE, ONE, 0, 0}, 1'b0, none};
		dir[12] = '{'{EMAX, EMIN, ONE, 0, EMAX, EMIN, EMIN, 0, EMAX}, 1'b0, none};
		dir[13] = '{'{32'h3_8000, 32'hffff_4000, 32'h1234, 32'h0002_2000, ONE,
			32'hfffe_0000, 32'h10, 32'h7_0000, 32'hffff_fff0}, 1'b0, none};

		seg_thr  = '{0, 32'h7fff_ffff, -1, 1};
		seg_mode = '{0, 1, 1, 2};
		seg_n    = '{400, 100, 350, 400};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir[r])
			send_matrix(dir[r].m, dir[r].chk, dir[r].res);

		for (int s = 0; s < 4; s++) begin
			write_threshold(seg_thr[s] < 0 ? 31'($urandom_range(1, 32'h7fff)) :
				31'(seg_thr[s]));
			tx_pct = (seg_mode[s] == 0) ? 11 : (seg_mode[s] == 1) ? 73 : 0;
			rx_pct = (seg_mode[s] == 0) ? 73 : (seg_mode[s] == 1) ? 11 : 0;
			if (s == 3)
				hold_go = 1'b1;
			// zero determinant with this threshold
			a = '{default: 32'h0};
			send_matrix(a, 1'b0, none);
			for (int n = 0; n < seg_n[s]; n++) begin
				kind = $urandom_range(0, 9);
				for (int k = 0; k < 9; k++) begin
					case (kind)
						0, 1:    a[k] = $urandom;
						2, 3, 4: a[k] = $urandom_range(0, 32'h10_0000) - 32'h8_0000;
						5, 6:    a[k] = (k % 4 == 0) ? $urandom_range(0, 32'h40_0000)
							- 32'h20_0000 : $urandom_range(0, 32'h2000) - 32'h1000;
						7:       a[k] = $urandom_range(0, 32'h1_0000) - 32'h8000;
						default: a[k] = pick[$urandom_range(0, 4)];
					endcase
				end
				if (kind == 7) begin
					a[6] = a[0]; a[7] = a[1]; a[8] = a[2];
				end
				send_matrix(a, 1'b0, none);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (inv_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (!failed)
			$display("matrix3x3_inverse: match");
		else
			$display("matrix3x3_inverse: mismatch");
		$finish;
	end

endmodule
